>>> sv/omlt_pkg.sv
// ----------------------------------------------------------------------------
// omlt_pkg
// Shared types and constants for the outstanding miss latency table.
// ----------------------------------------------------------------------------
package omlt_pkg;
   localparam int TableDepth = 128;
   localparam int TagWidth   = 32;
   localparam int TimeWidth  = 12;
   localparam int IdxWidth   = $clog2(TableDepth);
   localparam int AvgWidth   = 20;

   localparam logic [AvgWidth-1:0]  AvgReset = 20'd45568;
   localparam logic [TimeWidth-1:0] MinSampleReset = 12'd10;

   localparam logic [1:0] OpAddPrefetch = 2'd0;
   localparam logic [1:0] OpAddDemand   = 2'd1;
   localparam logic [1:0] OpFill        = 2'd2;
   localparam logic [1:0] OpQuery       = 2'd3;

   localparam logic [1:0] TlTimely  = 2'd0;
   localparam logic [1:0] TlLate    = 2'd1;
   localparam logic [1:0] TlTooLate = 2'd2;

   typedef struct packed {
      logic [1:0]           opcode;
      logic [TagWidth-1:0]  line_tag;
      logic [TimeWidth-1:0] now;
   } req_type;

   typedef struct packed {
      logic                 found;
      logic                 was_demand;
      logic [TimeWidth-1:0] age;
      logic [1:0]           timeliness;
      logic [AvgWidth-1:0]  mean_latency;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture request
      logic scan;     // compare one entry
      logic clear;    // reset scan
      logic finish;   // apply update
      logic mul;      // average step 1
      logic div;      // average step 2
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic last;     // scanned last entry
      logic need_avg; // fill updates average
   } sts_type;
endpackage

>>> sv/omlt_if.sv
// ----------------------------------------------------------------------------
// omlt_req_if / omlt_rsp_if
// Valid/ready channels for request and response beats.
// ----------------------------------------------------------------------------
interface omlt_req_if;
   import omlt_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface omlt_rsp_if;
   import omlt_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/outstanding_miss_latency_table_unit.sv
// ----------------------------------------------------------------------------
// outstanding_miss_latency_table_unit
// Table of outstanding line requests with running DRAM latency average.
// ----------------------------------------------------------------------------
// Request beats carry opcode, line_tag and now; each yields one response beat
// with found, was_demand, age, timeliness and mean_latency.
// A request is taken only while the unit is idle. Its tag lookup and victim
// choice walk the table one entry per cycle through a registered read; a fill
// that updates the mean adds a multiply and a divide step. The next request is
// taken the cycle after the response beat goes.
// The response holds in its register while rsp_ready is low.
// csr_write_enable/csr_write_data set min_sample_latency (reset 10).
// Reset empties the table and sets the mean to 178.0.
// ----------------------------------------------------------------------------
module outstanding_miss_latency_table_unit (
   input  logic        clock,
   input  logic        reset,
   omlt_req_if.sink    req,
   omlt_rsp_if.source  rsp,
   input  logic        csr_write_enable,
   input  logic [11:0] csr_write_data
);
   import omlt_pkg::*;

   cmd_type     cmd;
   sts_type     sts;
   logic [11:0] min_sample_ff;

   always_ff @(posedge clock) begin
      if (reset) min_sample_ff <= MinSampleReset;
      else if (csr_write_enable) min_sample_ff <= csr_write_data;
   end

   omlt_ctrl u_ctrl (
      .clock, .reset,
      .req_valid (req.valid), .req_ready (req.ready),
      .rsp_valid (rsp.valid), .rsp_ready (rsp.ready),
      .sts, .cmd
   );

   omlt_dp u_dp (
      .clock, .reset, .cmd,
      .req_data (req.payload), .min_sample (min_sample_ff),
      .sts, .rsp_data (rsp.payload)
   );
endmodule

>>> sv/omlt_dp.sv
// ----------------------------------------------------------------------------
// omlt_dp
// Entry registers, serial tag/victim scan, average update and response build.
// ----------------------------------------------------------------------------
module omlt_dp (
   input  logic               clock,
   input  logic               reset,
   input  omlt_pkg::cmd_type  cmd,
   input  omlt_pkg::req_type  req_data,
   input  logic [11:0]        min_sample,
   output omlt_pkg::sts_type  sts,
   output omlt_pkg::rsp_type  rsp_data
);
   import omlt_pkg::*;

   logic [TableDepth-1:0] valid_ff, valid_in;
   logic [TagWidth-1:0]   tag_ff  [TableDepth];
   logic [TimeWidth-1:0]  time_ff [TableDepth];
   logic                  dem_ff  [TableDepth];

   req_type               cur_ff;
   logic [IdxWidth-1:0]   idx_ff;
   logic                  rd_vld_ff;
   logic [IdxWidth-1:0]   rd_idx_ff;
   logic [TagWidth-1:0]   rd_tag_ff;
   logic [TimeWidth-1:0]  rd_time_ff;
   logic                  rd_dem_ff;
   logic                  hit_ff;
   logic [IdxWidth-1:0]   hit_idx_ff;
   logic [TimeWidth-1:0]  hit_time_ff;
   logic                  hit_dem_ff;
   logic                  free_ff;
   logic [IdxWidth-1:0]   vic_ff;
   logic [TimeWidth-1:0]  vic_age_ff;
   logic [AvgWidth-1:0]   avg_ff;
   logic [AvgWidth+5:0]   sum_ff;
   rsp_type               out_ff;

   logic [TimeWidth-1:0]  scan_age;
   logic [TimeWidth-1:0]  hit_age;
   logic                  hit_dem;
   logic                  sel_valid;
   logic [1:0]            tl;
   logic                  is_add;
   logic                  fill_ok;
   logic [IdxWidth-1:0]   wr_idx;
   logic [AvgWidth-1:0]   quo;

   assign sel_valid = valid_ff[rd_idx_ff];
   assign scan_age  = cur_ff.now - rd_time_ff;
   assign hit_age   = hit_ff ? cur_ff.now - hit_time_ff : '0;
   assign hit_dem   = hit_ff && hit_dem_ff;
   assign wr_idx    = free_ff ? hit_idx_ff : vic_ff;
   assign is_add    = (cur_ff.opcode == OpAddPrefetch) || (cur_ff.opcode == OpAddDemand);
   assign fill_ok   = (cur_ff.opcode == OpFill) && hit_ff && (cur_ff.line_tag != '0);
   assign sts.last     = rd_vld_ff && (rd_idx_ff == IdxWidth'(TableDepth - 1));
   assign sts.need_avg = fill_ok && hit_dem && (hit_age > min_sample);
   assign rsp_data = out_ff;

   always_comb begin
      if (!hit_ff)
         tl = TlTimely;
      else if ({hit_age, 8'd0} > avg_ff)
         tl = TlTimely;
      else if (({11'd0, hit_age} * 23'd1280) > {3'd0, avg_ff})
         tl = TlLate;
      else
         tl = TlTooLate;
   end

   // divide by 20 via reciprocal: floor(x*53687092 >> 30) exact for x < 2^26
   assign quo = AvgWidth'((52'(sum_ff) * 52'd53687092) >> 30);

   always_comb begin
      valid_in = valid_ff;
      if (cmd.finish) begin
         if (is_add && !hit_ff)
            valid_in[wr_idx] = 1'b1;
         if (fill_ok)
            valid_in[hit_idx_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         avg_ff   <= AvgReset;
      end else begin
         valid_ff <= valid_in;
         if (cmd.div)
            avg_ff <= quo;
      end
      rd_vld_ff  <= cmd.scan;
      rd_idx_ff  <= idx_ff;
      rd_tag_ff  <= tag_ff[idx_ff];
      rd_time_ff <= time_ff[idx_ff];
      rd_dem_ff  <= dem_ff[idx_ff];
      if (cmd.load)
         cur_ff <= req_data;
      if (cmd.clear) begin
         idx_ff     <= '0;
         hit_ff     <= 1'b0;
         free_ff    <= 1'b0;
         vic_ff     <= '0;
         vic_age_ff <= '0;
         hit_idx_ff <= '0;
      end else if (cmd.scan) begin
         idx_ff <= idx_ff + 1'b1;
         if (rd_vld_ff) begin
            if (sel_valid && rd_tag_ff == cur_ff.line_tag && !hit_ff) begin
               hit_ff      <= 1'b1;
               hit_idx_ff  <= rd_idx_ff;
               hit_time_ff <= rd_time_ff;
               hit_dem_ff  <= rd_dem_ff;
            end
            if (!sel_valid && !free_ff && !hit_ff) begin
               free_ff    <= 1'b1;
               hit_idx_ff <= rd_idx_ff;
            end
            if (sel_valid && !free_ff && scan_age > vic_age_ff) begin
               vic_age_ff <= scan_age;
               vic_ff     <= rd_idx_ff;
            end
         end
      end
      if (cmd.finish) begin
         if (is_add && !hit_ff) begin
            tag_ff [wr_idx] <= cur_ff.line_tag;
            time_ff[wr_idx] <= cur_ff.now;
            dem_ff [wr_idx] <= cur_ff.opcode[0];
         end
         out_ff.found        <= hit_ff;
         out_ff.was_demand   <= hit_dem;
         out_ff.age          <= hit_age;
         out_ff.timeliness   <= tl;
         out_ff.mean_latency <= avg_ff;
      end
      if (cmd.mul)
         sum_ff <= {6'd0, avg_ff} * 26'd19 + {6'd0, hit_age, 8'd0};
      if (cmd.div)
         out_ff.mean_latency <= quo;
   end
endmodule

>>> sv/omlt_ctrl.sv
// ----------------------------------------------------------------------------
// omlt_ctrl
// Sequencer: accept, scan, update, average, respond.
// ----------------------------------------------------------------------------
module omlt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  omlt_pkg::sts_type sts,
   output omlt_pkg::cmd_type cmd
);
   import omlt_pkg::*;

   typedef enum logic [2:0] {IDLE, SCAN, FIN, MUL, DIV, RESP} state_type;
   state_type state_ff, state_in;

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = (state_ff == RESP);

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         IDLE: begin
            cmd.clear = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = SCAN;
            end
         end
         SCAN: begin
            cmd.scan = 1'b1;
            if (sts.last) state_in = FIN;
         end
         FIN: begin
            cmd.finish = 1'b1;
            state_in = sts.need_avg ? MUL : RESP;
         end
         MUL: begin
            cmd.mul = 1'b1;
            state_in = DIV;
         end
         DIV: begin
            cmd.div = 1'b1;
            state_in = RESP;
         end
         RESP: if (rsp_ready) state_in = IDLE;
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= IDLE;
      else       state_ff <= state_in;
   end
endmodule

>>> sv/omlt_chk.sv
// ----------------------------------------------------------------------------
// omlt_chk
// Port-level checks for the latency table unit.
// ----------------------------------------------------------------------------
module omlt_chk (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [1:0] rsp_tl,
   input logic rsp_found
);
   import omlt_pkg::*;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready during response");
   a_rsp_after: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> req_ready) else $error("no return to idle");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("accepted twice");
   a_tl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_tl == TlTimely) else $error("absent not timely");
endmodule

bind outstanding_miss_latency_table_unit omlt_chk u_chk (
   .clock, .reset,
   .req_valid (req.valid), .req_ready (req.ready),
   .rsp_valid (rsp.valid), .rsp_ready (rsp.ready),
   .rsp_tl (rsp.payload.timeliness), .rsp_found (rsp.payload.found)
);
